@@ rtl/sfir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types, constants and coefficient tables for the stereo FIR lowpass.
// ----------------------------------------------------------------------------
package sfir_pkg;

  // filter geometry and number formats
  localparam int TAPS           = 32;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int TAP_IDX_W      = $clog2(TAPS);
  localparam int PROD_W         = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W          = PROD_W + TAP_IDX_W + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [TAP_IDX_W-1:0]          tap_idx_t;

  // coefficient set select
  typedef enum logic {
    MODE_DELAY   = 1'b0,
    MODE_LOWPASS = 1'b1
  } mode_t;

  localparam tap_idx_t CENTER_TAP = tap_idx_t'(TAPS / 2);
  localparam tap_idx_t LAST_TAP   = tap_idx_t'(TAPS - 1);
  localparam coef_t    COEF_ONE   = coef_t'(2 ** COEF_FRAC_BITS);

  // rounding and saturation constants
  localparam acc_t ROUND_HALF = acc_t'(2 ** (COEF_FRAC_BITS - 1));
  localparam acc_t SAT_MAX    = acc_t'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam acc_t SAT_MIN    = -acc_t'(2 ** (SAMPLE_BITS - 1));

  // hamming-windowed sinc, cutoff fs/4, center tap 0.5, Q2.16
  localparam coef_t LOWPASS_ROM [TAPS] = '{
    18'sd0,      -18'sd124,   18'sd0,      18'sd261,
    18'sd0,      -18'sd563,   18'sd0,      18'sd1090,
    18'sd0,      -18'sd1953,  18'sd0,      18'sd3428,
    18'sd0,      -18'sd6552,  18'sd0,      18'sd20812,
    18'sd32768,  18'sd20421,  18'sd0,      -18'sd6182,
    18'sd0,      18'sd3098,   18'sd0,      -18'sd1679,
    18'sd0,      18'sd881,    18'sd0,      -18'sd423,
    18'sd0,      18'sd188,    18'sd0,      -18'sd111
  };

  // control from the tap sequencer to the lanes and the output stage
  typedef struct packed {
    logic     shift;    // shift a new sample into the delay line
    logic     acc_clr;  // start a new sum
    logic     mul_en;   // multiply the selected tap
    logic     acc_en;   // add the registered product
    logic     load;     // hand the sums to the output register
    tap_idx_t tap;
    coef_t    coef;
  } seq_ctrl_t;

  // coefficient for one tap in the chosen mode
  function automatic coef_t coef_lookup(input mode_t mode, input tap_idx_t idx);
    coef_t c;
    c = '0;
    if (mode == MODE_LOWPASS) begin
      c = LOWPASS_ROM[idx];
    end else if (idx == CENTER_TAP) begin
      c = COEF_ONE;
    end
    return c;
  endfunction

endpackage

@@ rtl/sfir_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_if
// Valid/ready channels for stereo sample pairs in and filtered pairs out.
// ----------------------------------------------------------------------------
interface sfir_in_if;
  logic              valid;
  logic              ready;
  sfir_pkg::sample_t left_sample;
  sfir_pkg::sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfir_out_if;
  logic              valid;
  logic              ready;
  sfir_pkg::sample_t left_out;
  sfir_pkg::sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/sfir_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_lane
// One channel: delay line of the last TAPS samples and a multiply-accumulate.
// ----------------------------------------------------------------------------
module sfir_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  sfir_pkg::seq_ctrl_t ctrl,
  input  sfir_pkg::sample_t   sample,
  output sfir_pkg::acc_t      acc
);

  sfir_pkg::sample_t line_r [sfir_pkg::TAPS];
  sfir_pkg::prod_t   prod_r;
  sfir_pkg::acc_t    acc_r;

  // delay line, oldest sample at index 0, newest at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfir_pkg::TAPS; i++) begin
        line_r[i] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < sfir_pkg::TAPS - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[sfir_pkg::TAPS-1] <= sample;
    end
  end

  // product register, then accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= sfir_pkg::prod_t'(line_r[ctrl.tap]) * sfir_pkg::prod_t'(ctrl.coef);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + sfir_pkg::acc_t'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/sfir_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_seq
// Tap sequencer: walks both lanes through the taps in step for one pair.
// ----------------------------------------------------------------------------
module sfir_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfir_pkg::mode_t      mode,
  input  logic                 out_free,
  output sfir_pkg::seq_ctrl_t  ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_HOLD
  } state_t;

  state_t             state_r;
  sfir_pkg::tap_idx_t cnt_r;
  logic               in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // per-cycle lane and output controls
  always_comb begin
    ctrl         = '0;
    ctrl.shift   = in_fire;
    ctrl.acc_clr = in_fire;
    ctrl.mul_en  = (state_r == ST_MAC);
    ctrl.acc_en  = ((state_r == ST_MAC) && (cnt_r != '0)) || (state_r == ST_FLUSH);
    ctrl.load    = (state_r == ST_HOLD) && out_free;
    ctrl.tap     = cnt_r;
    ctrl.coef    = sfir_pkg::coef_lookup(mode, cnt_r);
  end

  // state and tap counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_fire) begin
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == sfir_pkg::LAST_TAP) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          cnt_r   <= '0;
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a new pair starts at the first tap
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MAC) && (cnt_r == '0))
    else $error("sfir_seq: accepted pair did not start at tap zero");

  // last tap is followed by the flush of the final product
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) && (cnt_r == sfir_pkg::LAST_TAP) |=> (state_r == ST_FLUSH))
    else $error("sfir_seq: missing flush after last tap");

  // output load happens once and returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> (state_r == ST_IDLE) && !ctrl.load)
    else $error("sfir_seq: output load not followed by idle");

endmodule

@@ rtl/sfir_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_merge
// Rounds and saturates both lane sums and holds the pair for the result beat.
// ----------------------------------------------------------------------------
module sfir_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sfir_pkg::acc_t      acc_left,
  input  sfir_pkg::acc_t      acc_right,
  output logic                out_free,
  sfir_out_if.source          out_ch
);

  logic              valid_r;
  sfir_pkg::sample_t left_r;
  sfir_pkg::sample_t right_r;

  // round half up, then clamp to the sample range
  function automatic sfir_pkg::sample_t round_sat(input sfir_pkg::acc_t a);
    sfir_pkg::acc_t v;
    sfir_pkg::sample_t y;
    v = (a + sfir_pkg::ROUND_HALF) >>> sfir_pkg::COEF_FRAC_BITS;
    if (v > sfir_pkg::SAT_MAX) begin
      y = sfir_pkg::sample_t'(sfir_pkg::SAT_MAX);
    end else if (v < sfir_pkg::SAT_MIN) begin
      y = sfir_pkg::sample_t'(sfir_pkg::SAT_MIN);
    end else begin
      y = v[sfir_pkg::SAMPLE_BITS-1:0];
    end
    return y;
  endfunction

  assign out_free = !valid_r || out_ch.ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= round_sat(acc_left);
      right_r <= round_sat(acc_right);
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;

  // a load never overwrites a pair that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !valid_r || out_ch.ready)
    else $error("sfir_merge: result overwritten before its beat");

  // a loaded pair is offered on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("sfir_merge: loaded pair not offered");

endmodule

@@ rtl/stereo_fir_lowpass_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fir_lowpass_filter_top
// Stereo 32-tap FIR, center-tap delay or windowed-sinc lowpass per filter mode.
// ----------------------------------------------------------------------------
// Each accepted beat on in_ch carries a left/right sample pair; both channels
// run through their own lane with one multiply-accumulate per tap per clock.
// After the pair is accepted, the lanes walk all taps, a flush step adds the
// last product and the sums are loaded into the output register; only then
// is the next pair taken, or later while the previous pair still waits for
// its result beat. A finished pair waits in the output register while the next
// pair is already being filtered. filter_mode (cfg_wdata on cfg_we) selects
// the pure delay of TAPS/2 - 1 items (0, reset) or the fs/4 lowpass (1); write
// it only when the block is idle. Results are rounded half up and saturated to
// 24 bits.
// ----------------------------------------------------------------------------
module stereo_fir_lowpass_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  sfir_in_if.sink    in_ch,
  sfir_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  sfir_pkg::mode_t     mode_r;
  sfir_pkg::seq_ctrl_t ctrl;
  sfir_pkg::acc_t      acc_left;
  sfir_pkg::acc_t      acc_right;
  logic                out_free;
  logic                seq_in_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sfir_pkg::MODE_DELAY;
    end else if (cfg_we) begin
      mode_r <= sfir_pkg::mode_t'(cfg_wdata);
    end
  end

  sfir_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (seq_in_ready),
    .mode     (mode_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = seq_in_ready;

  // left and right lanes run in step
  sfir_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_ch.left_sample),
    .acc    (acc_left)
  );

  sfir_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_ch.right_sample),
    .acc    (acc_right)
  );

  sfir_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctrl.load),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule
